[src/aap_pkg.sv]
package aap_pkg;

  localparam int POS_W = 7;
  localparam int OUTW_REG_W = 5;
  localparam int PIX_W = 8;
  localparam int SUM_W = 20;
  localparam int K_W = 14;
  localparam int NUM_W = 22;
  localparam int DEN_W = 15;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 7;
  localparam int ROW_W = 6;
  localparam int COL_W = 4;
  localparam int CHAN_W = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_HEIGHT  = 3'd0,
    REG_IN_WIDTH   = 3'd1,
    REG_CHANNELS   = 3'd2,
    REG_OUT_HEIGHT = 3'd3,
    REG_OUT_WIDTH  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
    logic [DEN_W-1:0] rem;
  } div_rsp_t;

endpackage

[src/aap_if.sv]
interface aap_in_if import aap_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             start_of_tensor;

  modport source (output valid, output pixel, output start_of_tensor, input ready);
  modport sink (input valid, input pixel, input start_of_tensor, output ready);
endinterface

interface aap_out_if import aap_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  average;
  logic [ROW_W-1:0]  out_row;
  logic [COL_W-1:0]  out_col;
  logic [CHAN_W-1:0] channel;
  logic              last;

  modport source (output valid, output average, output out_row, output out_col,
                  output channel, output last, input ready);
  modport sink (input valid, input average, input out_row, input out_col,
                input channel, input last, output ready);
endinterface

interface aap_cfg_if import aap_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[src/aap_ram.sv]
module aap_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/aap_div.sv]
module aap_div import aap_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [NUM_W-1:0]     quot;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     den;
  logic                 done;
  logic [DEN_W:0]       trial;
  logic                 fits;

  assign trial = {rem, quot[NUM_W-1]};
  assign fits = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= DIV_CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot <= req.num;
      rem <= '0;
      den <= req.den;
    end else if (busy) begin
      quot <= {quot[NUM_W-2:0], fits};
      rem <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem = rem;

endmodule

[src/adaptive_average_pool_u8_core.sv]
// A sample outside every window needs no sum update; one inside a window reads its
// sum from the memory, then writes it back; a sample that closes a window then waits for
// the 22-step shared divider that forms the rounded mean before the result is loaded.
// A new sample is taken only in the idle state, after the previous one is finished.
// Reset clears the 20-bit sum memory one entry per cycle (all MAX_OUT_W*MAX_CH entries),
// then derives the strides; a register write repeats that step.
module adaptive_average_pool_u8_core import aap_pkg::*; #(
  parameter int MAX_OUT_W = 16,
  parameter int MAX_CH = 64,
  parameter int MAX_DIM = 64
) (
  input logic clk,
  input logic rst,
  aap_in_if.sink samples,
  aap_out_if.source results,
  aap_cfg_if.sink cfg
);

  localparam int DEPTH = MAX_OUT_W * MAX_CH;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [POS_W-1:0] DIM_LIM = POS_W'((MAX_DIM > 127) ? 127 : MAX_DIM);
  localparam logic [POS_W-1:0] CH_LIM = POS_W'((MAX_CH > 127) ? 127 : MAX_CH);
  localparam logic [POS_W-1:0] OUTW_LIM = POS_W'((MAX_OUT_W > 127) ? 127 : MAX_OUT_W);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_CFG_SH = 10'b0000000010,
    S_CFG_SW = 10'b0000000100,
    S_CFG_K  = 10'b0000001000,
    S_CFG_HO = 10'b0000010000,
    S_CFG_WO = 10'b0000100000,
    S_IDLE   = 10'b0001000000,
    S_READ   = 10'b0010000000,
    S_DIV    = 10'b0100000000,
    S_EMIT   = 10'b1000000000
  } state_t;

  state_t state, state_next;

  logic [POS_W-1:0]      in_height, in_width, channels, out_height;
  logic [OUTW_REG_W-1:0] out_width;
  logic                  dirty;
  logic                  issued;
  logic [POS_W-1:0]      sh, sw;
  logic [K_W-1:0]        k;
  logic [POS_W-1:0]      row_pos, col_pos, chan_pos, ho, n, wo, m;
  logic [POS_W-1:0]      row_pos_next, col_pos_next, chan_pos_next;
  logic [POS_W-1:0]      ho_next, n_next, wo_next, m_next;
  logic [ADDR_W-1:0]     clr_addr;

  logic [PIX_W-1:0]  pix_q;
  logic              first_q, endw_q, last_q;
  logic [ROW_W-1:0]  ho_q;
  logic [COL_W-1:0]  wo_q;
  logic [CHAN_W-1:0] chan_q;
  logic [ADDR_W-1:0] addr_q;

  logic              res_valid;
  logic [PIX_W-1:0]  res_avg;
  logic [ROW_W-1:0]  res_row;
  logic [COL_W-1:0]  res_col;
  logic [CHAN_W-1:0] res_chan;
  logic              res_last;

  logic [POS_W-1:0] ih, iw, ch, oh, ow, ow_lim, ow_raw;
  logic             cfg_we, in_accept, emit_load, cfg_div_state;
  logic             wrap, active, first, endw, last;
  logic [POS_W-1:0] row_e, col_e, chan_e, ho_e, n_e, wo_e, m_e;
  logic [31:0]      addr_full;
  logic [ADDR_W-1:0] addr_e;
  logic [SUM_W-1:0] sum, ram_rdata;
  logic             ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [SUM_W-1:0] ram_wdata;
  logic [PIX_W-1:0] avg;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign ih = (in_height == '0) ? POS_W'(1) : ((in_height > DIM_LIM) ? DIM_LIM : in_height);
  assign iw = (in_width == '0) ? POS_W'(1) : ((in_width > DIM_LIM) ? DIM_LIM : in_width);
  assign ch = (channels == '0) ? POS_W'(1) : ((channels > CH_LIM) ? CH_LIM : channels);
  assign oh = (out_height == '0) ? POS_W'(1) : ((out_height > ih) ? ih : out_height);
  assign ow_lim = (iw < OUTW_LIM) ? iw : OUTW_LIM;
  assign ow_raw = POS_W'(out_width);
  assign ow = (ow_raw == '0) ? POS_W'(1) : ((ow_raw > ow_lim) ? ow_lim : ow_raw);

  assign cfg.ready = 1'b1;
  assign cfg_we = cfg.valid;
  assign samples.ready = (state == S_IDLE) && !dirty && !cfg.valid;
  assign in_accept = samples.valid && samples.ready;
  assign emit_load = (state == S_EMIT) && (!res_valid || results.ready);
  assign cfg_div_state = (state == S_CFG_SH) || (state == S_CFG_SW) ||
                         (state == S_CFG_HO) || (state == S_CFG_WO);

  always_comb begin
    wrap = samples.start_of_tensor || (row_pos >= ih) || (col_pos >= iw) || (chan_pos >= ch);
    row_e = wrap ? '0 : row_pos;
    col_e = wrap ? '0 : col_pos;
    chan_e = wrap ? '0 : chan_pos;
    ho_e = wrap ? '0 : ho;
    n_e = wrap ? '0 : n;
    wo_e = wrap ? '0 : wo;
    m_e = wrap ? '0 : m;
    active = (ho_e < oh) && (wo_e < ow);
    first = (n_e == '0) && (m_e == '0);
    endw = (n_e == sh - 1'b1) && (m_e == sw - 1'b1);
    last = (ho_e == oh - 1'b1) && (wo_e == ow - 1'b1) && (chan_e == ch - 1'b1);
    addr_full = 32'(wo_e) * 32'(MAX_CH) + 32'(chan_e);
    addr_e = addr_full[ADDR_W-1:0];

    row_pos_next = row_e;
    col_pos_next = col_e;
    chan_pos_next = chan_e + 1'b1;
    ho_next = ho_e;
    n_next = n_e;
    wo_next = wo_e;
    m_next = m_e;
    if (chan_e + 1'b1 >= ch) begin
      chan_pos_next = '0;
      if (col_e + 1'b1 >= iw) begin
        col_pos_next = '0;
        m_next = '0;
        wo_next = '0;
        if (row_e + 1'b1 >= ih) begin
          row_pos_next = '0;
          n_next = '0;
          ho_next = '0;
        end else begin
          row_pos_next = row_e + 1'b1;
          if (n_e == sh - 1'b1) begin
            n_next = '0;
            ho_next = ho_e + 1'b1;
          end else begin
            n_next = n_e + 1'b1;
          end
        end
      end else begin
        col_pos_next = col_e + 1'b1;
        if (m_e == sw - 1'b1) begin
          m_next = '0;
          wo_next = wo_e + 1'b1;
        end else begin
          m_next = m_e + 1'b1;
        end
      end
    end
  end

  assign sum = first_q ? SUM_W'(pix_q) : ram_rdata + SUM_W'(pix_q);

  assign ram_we = (state == S_CLEAR) || (state == S_READ);
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : addr_q;
  assign ram_wdata = (state == S_CLEAR) ? '0 : sum;

  aap_ram #(
    .WIDTH(SUM_W),
    .DEPTH(DEPTH)
  ) u_sums (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(addr_e),
    .rdata(ram_rdata)
  );

  always_comb begin
    div_req.start = (cfg_div_state && !issued) || ((state == S_READ) && endw_q);
    case (state)
      S_CFG_SH: begin
        div_req.num = NUM_W'(ih);
        div_req.den = DEN_W'(oh);
      end
      S_CFG_SW: begin
        div_req.num = NUM_W'(iw);
        div_req.den = DEN_W'(ow);
      end
      S_CFG_HO: begin
        div_req.num = NUM_W'(row_pos);
        div_req.den = DEN_W'(sh);
      end
      S_CFG_WO: begin
        div_req.num = NUM_W'(col_pos);
        div_req.den = DEN_W'(sw);
      end
      default: begin
        div_req.num = NUM_W'({sum, 1'b0}) + NUM_W'(k);
        div_req.den = {k, 1'b0};
      end
    endcase
  end

  aap_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  assign avg = (|div_rsp.quot[NUM_W-1:PIX_W]) ? '1 : div_rsp.quot[PIX_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = S_CFG_SH;
      S_CFG_SH: if (div_rsp.done) state_next = S_CFG_SW;
      S_CFG_SW: if (div_rsp.done) state_next = S_CFG_K;
      S_CFG_K: state_next = S_CFG_HO;
      S_CFG_HO: if (div_rsp.done) state_next = S_CFG_WO;
      S_CFG_WO: if (div_rsp.done) state_next = S_IDLE;
      S_IDLE: begin
        if (dirty) begin
          state_next = S_CFG_SH;
        end else if (in_accept && active) begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = endw_q ? S_DIV : S_IDLE;
      S_DIV: if (div_rsp.done) state_next = S_EMIT;
      S_EMIT: if (emit_load) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      dirty <= 1'b0;
      issued <= 1'b0;
      in_height <= POS_W'(8);
      in_width <= POS_W'(8);
      channels <= POS_W'(1);
      out_height <= POS_W'(1);
      out_width <= OUTW_REG_W'(1);
      row_pos <= '0;
      col_pos <= '0;
      chan_pos <= '0;
      ho <= '0;
      n <= '0;
      wo <= '0;
      m <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end

      if (cfg_we) begin
        dirty <= 1'b1;
        unique case (cfg_reg_t'(cfg.index))
          REG_IN_HEIGHT: in_height <= cfg.data;
          REG_IN_WIDTH: in_width <= cfg.data;
          REG_CHANNELS: channels <= cfg.data;
          REG_OUT_HEIGHT: out_height <= cfg.data;
          REG_OUT_WIDTH: out_width <= cfg.data[OUTW_REG_W-1:0];
          default: ;
        endcase
      end else if (state == S_IDLE) begin
        dirty <= 1'b0;
      end

      if (cfg_div_state) begin
        if (div_rsp.done) begin
          issued <= 1'b0;
        end else if (!issued) begin
          issued <= 1'b1;
        end
      end

      if (state == S_CFG_HO && div_rsp.done) begin
        ho <= div_rsp.quot[POS_W-1:0];
        n <= div_rsp.rem[POS_W-1:0];
      end
      if (state == S_CFG_WO && div_rsp.done) begin
        wo <= div_rsp.quot[POS_W-1:0];
        m <= div_rsp.rem[POS_W-1:0];
      end

      if (in_accept) begin
        row_pos <= row_pos_next;
        col_pos <= col_pos_next;
        chan_pos <= chan_pos_next;
        ho <= ho_next;
        n <= n_next;
        wo <= wo_next;
        m <= m_next;
      end

      if (emit_load) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CFG_SH && div_rsp.done) begin
      sh <= div_rsp.quot[POS_W-1:0];
    end
    if (state == S_CFG_SW && div_rsp.done) begin
      sw <= div_rsp.quot[POS_W-1:0];
    end
    if (state == S_CFG_K) begin
      k <= K_W'(sh) * K_W'(sw);
    end
    if (in_accept) begin
      pix_q <= samples.pixel;
      first_q <= first;
      endw_q <= endw;
      last_q <= last;
      ho_q <= ho_e[ROW_W-1:0];
      wo_q <= wo_e[COL_W-1:0];
      chan_q <= chan_e[CHAN_W-1:0];
      addr_q <= addr_e;
    end
    if (emit_load) begin
      res_avg <= avg;
      res_row <= ho_q;
      res_col <= wo_q;
      res_chan <= chan_q;
      res_last <= last_q;
    end
  end

  assign results.valid = res_valid;
  assign results.average = res_avg;
  assign results.out_row = res_row;
  assign results.out_col = res_col;
  assign results.channel = res_chan;
  assign results.last = res_last;

  assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV) || cfg_div_state)
    else $error("Divider finished while no state was waiting for it.");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> ($past(state) == S_DIV) || ($past(state) == S_EMIT))
    else $error("Result stage entered without a completed division.");

  assert property (@(posedge clk) disable iff (rst)
    dirty |-> !samples.ready)
    else $error("Sample taken before the strides were rederived.");

  assert property (@(posedge clk) disable iff (rst)
    ram_we && (state == S_READ) |-> $past(in_accept))
    else $error("Sum write-back without a sample transaction in the previous cycle.");

endmodule
